[hw/rtl/lcre_pkg.sv]
package lcre_pkg;

    // Field widths of the byte stream and of the run count.
    localparam int SYM_W = 8;
    localparam int CNT_W = 6;
    localparam int DIG_W = 4;
    // Wide enough for 63 * 10 + 9.
    localparam int SUM_W = 10;

    typedef logic [SYM_W-1:0] t_sym;
    typedef logic [CNT_W-1:0] t_cnt;
    typedef logic [SUM_W-1:0] t_sum;

    // Character codes of the encoded stream.
    localparam t_sym CH_A   = 8'h61;
    localparam t_sym CH_Z   = 8'h7A;
    localparam t_sym CH_SEP = 8'h2D;
    localparam t_sym CH_0   = 8'h30;
    localparam t_sym CH_9   = 8'h39;

endpackage

[hw/rtl/lcre_in_if.sv]
interface lcre_in_if import lcre_pkg::*; ();
    logic valid;
    logic ready;
    t_sym symbol;
    logic end_of_sequence;

    modport source (output valid, output symbol, output end_of_sequence, input ready);
    modport sink   (input valid, input symbol, input end_of_sequence, output ready);
endinterface

[hw/rtl/lcre_out_if.sv]
interface lcre_out_if import lcre_pkg::*; ();
    logic valid;
    logic ready;
    t_sym letter;
    logic last_of_run;

    modport source (output valid, output letter, output last_of_run, input ready);
    modport sink   (input valid, input letter, input last_of_run, output ready);
endinterface

[hw/rtl/letter_count_run_expander_unit.sv]
// Run-length expander for a byte stream of the form letter, count, '-', ...
// i_in carries one byte (symbol) and an end_of_sequence flag per item.
// Lower-case letters set the run letter, decimal digits build the count
// (saturating at MAX_RUN), and a '-' or a non-letter byte flagged
// end_of_sequence releases the run: o_out then carries the letter once per
// count, with last_of_run set on the final copy. Other bytes are ignored.
// A releasing item with a nonzero count puts the sequencer into its emit
// state, which loads the first copy into the output register. i_in.ready
// stays low until the last copy is loaded, one copy a cycle through the
// single output register while the receiver takes them; after any other
// item i_in.ready stays high. The count update and the copy down-counter
// share one adder, so one item is in work at a time. When the receiver
// stalls, the copy in the output register holds and the down-counter waits;
// the next item may be accepted while the final copy still waits to be taken.
// Reset (synchronous, active low) clears the run letter, the count, the
// sequencer and the output valid flag.
module letter_count_run_expander_unit import lcre_pkg::*; #(
    parameter int MAX_RUN = 63
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    lcre_in_if.sink    i_in,
    lcre_out_if.source o_out
);

    localparam t_cnt MAX_RUN_C = CNT_W'(MAX_RUN);

    typedef enum logic {
        S_IDLE,
        S_EMIT
    } t_state;

    t_state r_state;
    t_sym   r_run_letter;
    t_cnt   r_run_count;
    t_cnt   r_remain;
    logic   r_out_valid;
    t_sym   r_out_letter;
    logic   r_out_last;

    logic             acc_in;
    logic             is_letter;
    logic             is_sep;
    logic             is_digit;
    logic             emit;
    logic             out_free;
    logic             n_out_valid;
    logic [DIG_W-1:0] digit;
    t_sum             times10;
    t_sum             op_a;
    t_sum             op_b;
    t_sum             sum;
    t_cnt             sat_count;
    t_cnt             n_run_count;

    // Decode the incoming byte.
    assign acc_in    = i_in.valid && i_in.ready;
    assign is_letter = (i_in.symbol >= CH_A) && (i_in.symbol <= CH_Z);
    assign is_sep    = (i_in.symbol == CH_SEP);
    assign is_digit  = (i_in.symbol >= CH_0) && (i_in.symbol <= CH_9);
    assign digit     = DIG_W'(i_in.symbol - CH_0);
    assign emit      = is_sep || (!is_letter && i_in.end_of_sequence);
    assign out_free  = !r_out_valid || o_out.ready;

    // The output register is loaded with a new copy, or keeps a copy not yet taken.
    assign n_out_valid = ((r_state == S_EMIT) && out_free) || (r_out_valid && !o_out.ready);

    // Shared adder: count * 10 + digit while idle, copy counter minus one while emitting.
    assign times10 = (SUM_W'(r_run_count) << 3) + (SUM_W'(r_run_count) << 1);

    always_comb begin
        if (r_state == S_EMIT) begin
            op_a = SUM_W'(r_remain);
            op_b = '1;
        end else begin
            op_a = times10;
            op_b = SUM_W'(digit);
        end
    end

    assign sum         = op_a + op_b;
    assign sat_count   = (sum > SUM_W'(MAX_RUN_C)) ? MAX_RUN_C : sum[CNT_W-1:0];
    assign n_run_count = is_digit ? sat_count : r_run_count;

    // Sequencer, run state and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_run_letter <= '0;
            r_run_count  <= '0;
            r_remain     <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            unique case (r_state)
                S_IDLE: begin
                    if (acc_in) begin
                        if (is_letter) begin
                            r_run_letter <= i_in.symbol;
                        end
                        if (emit) begin
                            r_run_count <= '0;
                            if (n_run_count != '0) begin
                                r_remain <= n_run_count;
                                r_state  <= S_EMIT;
                            end
                        end else begin
                            r_run_count <= n_run_count;
                        end
                    end
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_out_letter <= r_run_letter;
                        r_out_last   <= (r_remain == CNT_W'(1));
                        r_remain     <= sum[CNT_W-1:0];
                        if (r_remain == CNT_W'(1)) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_in.ready        = (r_state == S_IDLE);
    assign o_out.valid       = r_out_valid;
    assign o_out.letter      = r_out_letter;
    assign o_out.last_of_run = r_out_last;

    // The copy counter never sits at zero while a run is being emitted.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> (r_remain != '0))
        else $error("copy counter is zero during emit");

    // The accumulated count never exceeds the saturation limit.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_run_count <= MAX_RUN_C))
        else $error("run count above limit");

    // A separator with a nonzero count starts emitting and clears the count.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc_in && is_sep && (r_run_count != '0))
            |=> ((r_state == S_EMIT) && (r_run_count == '0)))
        else $error("separator did not start a run");

    // Each copy loaded into the output register carries the run letter.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_EMIT) && out_free) |=> (r_out_valid && (r_out_letter == r_run_letter)))
        else $error("copy not loaded with run letter");

endmodule

[verif/letter_count_run_expander_unit_tb.sv]
`timescale 1ns / 100ps

module letter_count_run_expander_unit_tb;
    import lcre_pkg::*;

    localparam int RUN_LIMIT     = 63;
    localparam int ITEM_TARGET   = 500;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int TAIL_CYCLES   = 20;
    localparam int LONG_HOLD     = 300;
    localparam int HOLD_AFTER    = 400;
    localparam int DIRECTED_ROWS = 25;

    // One emitted copy of the run letter.
    typedef struct packed {
        t_sym letter;
        logic last_of_run;
    } t_copy;

    // One directed item; when typed is set, n copies of letter are expected.
    typedef struct packed {
        t_sym       sym;
        logic       eos;
        logic       typed;
        logic [6:0] n;
        t_sym       letter;
    } t_stim_row;

    logic i_clk = 1'b0;
    logic i_rst_n;

    lcre_in_if  in_if ();
    lcre_out_if out_if ();

    letter_count_run_expander_unit #(
        .MAX_RUN(RUN_LIMIT)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_if),
        .o_out  (out_if)
    );

    // Decoder state as the block should hold it.
    t_sym run_letter_q;
    t_cnt run_count_q;

    t_copy pending_copies[$];

    int error_count     = 0;
    int cycle_count     = 0;
    int items_offered   = 0;
    int items_counted   = 0;
    int copies_taken    = 0;
    bit pause_for_drain = 1'b0;
    bit long_hold_done  = 1'b0;

    // Directed items: reset state, saturation, zero count and the odd bytes.
    t_stim_row directed_rows [0:DIRECTED_ROWS-1] = '{
        '{CH_SEP,         1'b0, 1'b1, 7'd0,  8'h00},
        '{CH_0 + 8'd5,    1'b0, 1'b0, 7'd0,  8'h00},
        '{CH_SEP,         1'b0, 1'b1, 7'd5,  8'h00},
        '{CH_A,           1'b0, 1'b0, 7'd0,  8'h00},
        '{CH_9,           1'b0, 1'b0, 7'd0,  8'h00},
        '{CH_9,           1'b0, 1'b0, 7'd0,  8'h00},
        '{CH_SEP,         1'b0, 1'b1, 7'd63, CH_A},
        '{CH_Z,           1'b0, 1'b0, 7'd0,  8'h00},
        '{CH_0,           1'b0, 1'b0, 7'd0,  8'h00},
        '{CH_SEP,         1'b0, 1'b1, 7'd0,  8'h00},
        '{CH_0 + 8'd1,    1'b0, 1'b0, 7'd0,  8'h00},
        '{CH_0 + 8'd7,    1'b1, 1'b0, 7'd0,  8'h00},
        '{CH_A + 8'd1,    1'b0, 1'b0, 7'd0,  8'h00},
        '{CH_0 + 8'd3,    1'b0, 1'b0, 7'd0,  8'h00},
        '{CH_A + 8'd1,    1'b1, 1'b0, 7'd0,  8'h00},
        '{CH_SEP,         1'b0, 1'b0, 7'd0,  8'h00},
        '{8'h00,          1'b0, 1'b0, 7'd0,  8'h00},
        '{CH_A - 8'd1,    1'b0, 1'b0, 7'd0,  8'h00},
        '{CH_0 + 8'd4,    1'b0, 1'b0, 7'd0,  8'h00},
        '{CH_Z + 8'd1,    1'b0, 1'b0, 7'd0,  8'h00},
        '{CH_0 - 8'd1,    1'b0, 1'b0, 7'd0,  8'h00},
        '{CH_9 + 8'd1,    1'b0, 1'b0, 7'd0,  8'h00},
        '{8'hFF,          1'b1, 1'b0, 7'd0,  8'h00},
        '{CH_0 + 8'd2,    1'b0, 1'b0, 7'd0,  8'h00},
        '{CH_SEP,         1'b1, 1'b0, 7'd0,  8'h00}
    };

    always #5 i_clk = ~i_clk;

    // Update the decoder state for one byte and return how many copies it releases.
    function automatic int unsigned expand_run(input t_sym sym, input logic eos,
                                               output t_sym copy_letter);
        t_sum        sum;
        logic        release_now;
        int unsigned copies;
        release_now = 1'b0;
        copies      = 0;
        if (sym >= CH_A && sym <= CH_Z) begin
            run_letter_q = sym;
        end else if (sym == CH_SEP) begin
            release_now = 1'b1;
        end else if (sym >= CH_0 && sym <= CH_9) begin
            sum         = t_sum'(run_count_q * 10 + (sym - CH_0));
            run_count_q = (sum > RUN_LIMIT) ? t_cnt'(RUN_LIMIT) : t_cnt'(sum);
            release_now = eos;
        end else begin
            release_now = eos;
        end
        copy_letter = run_letter_q;
        if (release_now) begin
            copies      = 32'(run_count_q);
            run_count_q = '0;
        end
        return copies;
    endfunction

    // Offer one item, wait for it to be taken, then queue the copies it releases.
    task automatic offer_item(input t_sym sym, input logic eos, input bit typed,
                              input int unsigned typed_n, input t_sym typed_letter);
        int unsigned gap;
        int unsigned copies;
        t_sym        copy_letter;
        gap = ((items_offered / 48) % 3 == 1) ? 0 : $urandom_range(0, 7);
        items_offered++;
        if (gap > 0 || pause_for_drain) begin
            in_if.valid <= 1'b0;
        end
        // Let the block run dry before going on.
        if (pause_for_drain) begin
            pause_for_drain = 1'b0;
            do @(posedge i_clk); while (pending_copies.size() != 0);
        end
        repeat (gap) @(posedge i_clk);
        in_if.valid           <= 1'b1;
        in_if.symbol          <= sym;
        in_if.end_of_sequence <= eos;
        do @(posedge i_clk); while (!(in_if.valid && in_if.ready));

        copies = expand_run(sym, eos, copy_letter);
        if (typed) begin
            copies      = typed_n;
            copy_letter = typed_letter;
        end
        for (int unsigned k = 0; k < copies; k++) begin
            pending_copies.push_back('{letter: copy_letter, last_of_run: (k + 1 == copies)});
        end
        if (eos || sym == CH_SEP || (sym >= CH_0 && sym <= CH_9)
                || (sym >= CH_A && sym <= CH_Z)) begin
            items_counted++;
        end
    endtask

    // A letter, a decimal count and a release, with the odd broken run.
    task automatic offer_random_run();
        t_sym        run_bytes[$];
        t_sym        odd_byte;
        int unsigned n;
        int unsigned ending;
        logic        last_eos;
        last_eos = 1'b0;
        if ($urandom_range(0, 5) != 0) begin
            run_bytes.push_back(t_sym'(CH_A + $urandom_range(0, 25)));
        end
        // Mostly short runs so that the run stays quick; now and then a large one.
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 99) : $urandom_range(0, 12);
        if (n != 0 || $urandom_range(0, 1) == 1) begin
            if ($urandom_range(0, 9) == 0) begin
                run_bytes.push_back(CH_0);
            end
            if (n >= 10) begin
                run_bytes.push_back(t_sym'(CH_0 + n / 10));
            end
            run_bytes.push_back(t_sym'(CH_0 + n % 10));
        end
        ending = $urandom_range(0, 9);
        case (ending)
            6: begin
                run_bytes.push_back(CH_SEP);
                last_eos = 1'b1;
            end
            7: begin
                // The last byte of the run itself ends the sequence.
                if (run_bytes.size() == 0) begin
                    run_bytes.push_back(CH_0);
                end
                last_eos = 1'b1;
            end
            8: begin
                do begin
                    odd_byte = t_sym'($urandom_range(0, 255));
                end while ((odd_byte >= CH_A && odd_byte <= CH_Z) || odd_byte == CH_SEP
                           || (odd_byte >= CH_0 && odd_byte <= CH_9));
                run_bytes.push_back(odd_byte);
                last_eos = 1'b1;
            end
            9: begin
                // No release: the count carries over into the next run.
            end
            default: begin
                run_bytes.push_back(CH_SEP);
            end
        endcase
        for (int i = 0; i < run_bytes.size(); i++) begin
            offer_item(run_bytes[i], last_eos && (i == run_bytes.size() - 1), 1'b0, 0, '0);
        end
    endtask

    // Compare every copy that leaves the block with the oldest one expected.
    always @(posedge i_clk) begin : check_copies
        t_copy want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            copies_taken++;
            if (pending_copies.size() == 0) begin
                error_count++;
                $display("%0t: unexpected copy letter %h last_of_run %b", $time,
                         out_if.letter, out_if.last_of_run);
            end else begin
                want = pending_copies.pop_front();
                if (out_if.letter !== want.letter) begin
                    error_count++;
                    $display("%0t: letter expected %h actual %h", $time,
                             want.letter, out_if.letter);
                end
                if (out_if.last_of_run !== want.last_of_run) begin
                    error_count++;
                    $display("%0t: last_of_run expected %b actual %b", $time,
                             want.last_of_run, out_if.last_of_run);
                end
            end
        end
    end

    // Give up if the run hangs.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Receiver: random stalls per copy, one long hold-off to back up the input.
    initial begin : drive_ready
        int unsigned stall;
        out_if.ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            stall = ((copies_taken / 48) % 3 == 2) ? 0 : $urandom_range(0, 7);
            if (!long_hold_done && copies_taken >= HOLD_AFTER) begin
                long_hold_done = 1'b1;
                stall          = LONG_HOLD;
            end
            if (stall > 0) begin
                out_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_if.ready <= 1'b1;
            do @(posedge i_clk); while (!(out_if.valid && out_if.ready));
        end
    end

    // Reset, directed items, random runs, then drain and report.
    initial begin
        bit drain_done;
        drain_done            = 1'b0;
        run_letter_q          = '0;
        run_count_q           = '0;
        in_if.valid           <= 1'b0;
        in_if.symbol          <= '0;
        in_if.end_of_sequence <= 1'b0;
        i_rst_n               <= 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < DIRECTED_ROWS; r++) begin
            offer_item(directed_rows[r].sym, directed_rows[r].eos, directed_rows[r].typed,
                       32'(directed_rows[r].n), directed_rows[r].letter);
        end

        while (items_counted < ITEM_TARGET) begin
            if (!drain_done && items_counted >= ITEM_TARGET / 2) begin
                drain_done      = 1'b1;
                pause_for_drain = 1'b1;
            end
            if ($urandom_range(0, 9) == 0) begin
                offer_item(t_sym'($urandom_range(0, 255)), ($urandom_range(0, 3) == 0),
                           1'b0, 0, '0);
            end else begin
                offer_random_run();
            end
        end
        in_if.valid <= 1'b0;

        while (pending_copies.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
